>>> hdl/assert_macros.svh
// Assertion helpers used by the key release debouncer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define KRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define KRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/krd_pkg.sv
`default_nettype none

package krd_pkg;

  // Field widths of the words that cross the ports.
  localparam int TIME_BITS     = 48;
  localparam int KEY_BITS      = 16;
  localparam int DEV_BITS      = 8;
  localparam int INTERVAL_BITS = 24;
  localparam int CODE_BITS     = 3;

  // Input item kinds. Codes six and seven behave as a tick.
  typedef enum logic [CODE_BITS-1:0] {
    KIND_PRESS   = 3'd0,
    KIND_RELEASE = 3'd1,
    KIND_REPEAT  = 3'd2,
    KIND_TICK    = 3'd3,
    KIND_QUERY   = 3'd4,
    KIND_CLEAR   = 3'd5
  } kind_t;

  // Result codes.
  typedef enum logic [CODE_BITS-1:0] {
    WHAT_PRESSED  = 3'd0,
    WHAT_RELEASED = 3'd1,
    WHAT_REPEATED = 3'd2,
    WHAT_REPORT   = 3'd3,
    WHAT_NONE     = 3'd4,
    WHAT_FULL     = 3'd5
  } what_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  // What the current table sweep is looking for.
  typedef enum logic [1:0] {
    MODE_FLUSH,
    MODE_QUERY,
    MODE_FIND
  } mode_t;

  // Input word.
  typedef struct packed {
    logic [CODE_BITS-1:0] kind;
    logic [TIME_BITS-1:0] event_time;
    logic [KEY_BITS-1:0]  key_code;
    logic [DEV_BITS-1:0]  device_id;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [CODE_BITS-1:0] what;
    logic [TIME_BITS-1:0] out_time;
    logic [KEY_BITS-1:0]  out_key_code;
    logic [DEV_BITS-1:0]  out_device_id;
    logic                 last;
  } out_word_t;

  // One row of the key table memory.
  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DEV_BITS-1:0]  dev;
    logic [TIME_BITS-1:0] rtime;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/key_release_debouncer.sv
`default_nettype none
// Channel    | Ports                          | Handshake
// -----------+--------------------------------+-------------------------------------
// input      | start, in_data, busy           | word taken when start=1 and busy=0
// result     | out_strobe, out_data           | word valid for the one strobe cycle
// config     | cfg_we, cfg_wdata              | interval written when cfg_we=1
//
// Each item but a zero-interval pass-through sweeps the key table through one deadline
// adder and comparator. A sweep reads each row through a registered memory read, then
// a deadline stage and a compare stage, then decides. A key event or query that flushes
// R releases runs R+2 sweeps, other kinds one sweep fewer; a pass-through runs none.
// A result is held until the next one is found or the item ends; the receiver cannot stall.
// Synchronous active-low reset empties the table and zeroes the interval.

module key_release_debouncer #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire krd_pkg::in_word_t                     in_data,
  output logic                                       busy,
  output logic                                       out_strobe,
  output krd_pkg::out_word_t                         out_data,
  input  wire logic                                  cfg_we,
  input  wire logic [krd_pkg::INTERVAL_BITS-1:0]     cfg_wdata
);

  import krd_pkg::*;

`include "assert_macros.svh"

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Control state.
  state_t                   state_r, state_nxt;
  mode_t                    mode_r;
  logic [INTERVAL_BITS-1:0] interval_r;
  in_word_t                 item_r;

  // Per-entry flag bits.
  logic [TABLE_DEPTH-1:0]   valid_r, down_r, pend_r;
  logic [TABLE_DEPTH-1:0]   valid_nxt, down_nxt, pend_nxt;

  // Key table memory.
  entry_t                   mem_r [TABLE_DEPTH];
  entry_t                   mem_rd_r;

  // Sweep pipeline.
  logic                     issue_r;
  logic [IDX_W-1:0]         cnt_r;
  logic                     p1_v_r;
  logic [IDX_W-1:0]         p1_idx_r;
  logic                     p2_v_r;
  logic [IDX_W-1:0]         p2_idx_r;
  logic [TIME_BITS-1:0]     p2_dl_r;
  logic [KEY_BITS-1:0]      p2_key_r;
  logic [DEV_BITS-1:0]      p2_dev_r;
  logic                     p2_cand_r, p2_match_r, p2_free_r;

  // Sweep results.
  logic                     best_found_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic [TIME_BITS-1:0]     best_dl_r;
  logic [KEY_BITS-1:0]      best_key_r;
  logic [DEV_BITS-1:0]      best_dev_r;
  logic                     match_found_r, free_found_r;
  logic [IDX_W-1:0]         match_idx_r, free_idx_r;

  // Held result and output register.
  logic                     held_v_r;
  out_word_t                held_r;
  logic                     out_strobe_r;
  out_word_t                out_r;

  // Combinational controls.
  logic                     accept, passthru, scan_end;
  logic                     scan_start;
  mode_t                    scan_mode;
  logic                     push, finish_emit;
  out_word_t                push_word;
  logic [IDX_W-1:0]         ent_idx;
  logic                     ent_valid_set, ent_flags_clr;
  logic                     ent_down_set, ent_down_clr, ent_pend_set, ent_pend_clr;
  logic                     clear_all;
  logic                     mem_we;
  entry_t                   mem_wdata;
  logic [IDX_W-1:0]         find_idx;
  logic                     cur_down, cur_pend;
  logic [TIME_BITS:0]       dl_sum;
  logic [TIME_BITS-1:0]     dl_sat;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign passthru   = (in_data.kind <= KIND_REPEAT) && (interval_r == '0);
  assign scan_end   = p2_v_r && (p2_idx_r == LAST_IDX);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  assign find_idx = match_found_r ? match_idx_r : free_idx_r;
  assign cur_down = match_found_r && down_r[find_idx];
  assign cur_pend = match_found_r && pend_r[find_idx];

  // Release deadline of the row just read, saturated to the largest time.
  assign dl_sum = {1'b0, mem_rd_r.rtime} + (TIME_BITS + 1)'(interval_r);
  assign dl_sat = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = passthru ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (mode_r == MODE_FLUSH &&
            (best_found_r || item_r.kind <= KIND_REPEAT || item_r.kind == KIND_QUERY)) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: sweeps, results and table updates.
  always_comb begin
    scan_start    = 1'b0;
    scan_mode     = MODE_FLUSH;
    push          = 1'b0;
    push_word     = '0;
    finish_emit   = 1'b0;
    ent_idx       = find_idx;
    ent_valid_set = 1'b0;
    ent_flags_clr = 1'b0;
    ent_down_set  = 1'b0;
    ent_down_clr  = 1'b0;
    ent_pend_set  = 1'b0;
    ent_pend_clr  = 1'b0;
    clear_all     = 1'b0;
    mem_we        = 1'b0;
    mem_wdata.key   = item_r.key_code;
    mem_wdata.dev   = item_r.device_id;
    mem_wdata.rtime = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (passthru) begin
            push                    = 1'b1;
            push_word.what          = in_data.kind;
            push_word.out_time      = in_data.event_time;
            push_word.out_key_code  = in_data.key_code;
            push_word.out_device_id = in_data.device_id;
          end else begin
            scan_start = 1'b1;
          end
        end
      end
      ST_SCAN: begin
      end
      ST_DECIDE: begin
        unique case (mode_r)
          MODE_FLUSH: begin
            if (best_found_r) begin
              // Emit the earliest expired release and sweep again.
              push                    = 1'b1;
              push_word.what          = WHAT_RELEASED;
              push_word.out_time      = best_dl_r;
              push_word.out_key_code  = best_key_r;
              push_word.out_device_id = best_dev_r;
              ent_idx                 = best_idx_r;
              ent_down_clr            = 1'b1;
              ent_pend_clr            = 1'b1;
              scan_start              = 1'b1;
            end else if (item_r.kind <= KIND_REPEAT) begin
              scan_start = 1'b1;
              scan_mode  = MODE_FIND;
            end else if (item_r.kind == KIND_QUERY) begin
              scan_start = 1'b1;
              scan_mode  = MODE_QUERY;
            end else if (item_r.kind == KIND_CLEAR) begin
              clear_all = 1'b1;
            end
          end
          MODE_QUERY: begin
            push = 1'b1;
            if (best_found_r) begin
              push_word.what     = WHAT_REPORT;
              push_word.out_time = best_dl_r;
            end else begin
              push_word.what = WHAT_NONE;
            end
          end
          MODE_FIND: begin
            if (!match_found_r && !free_found_r) begin
              push                    = 1'b1;
              push_word.what          = WHAT_FULL;
              push_word.out_time      = item_r.event_time;
              push_word.out_key_code  = item_r.key_code;
              push_word.out_device_id = item_r.device_id;
            end else begin
              // A new key takes the first free row with clear flags.
              if (!match_found_r) begin
                ent_valid_set = 1'b1;
                ent_flags_clr = 1'b1;
                mem_we        = 1'b1;
              end
              push_word.out_time      = item_r.event_time;
              push_word.out_key_code  = item_r.key_code;
              push_word.out_device_id = item_r.device_id;
              priority if (item_r.kind == KIND_PRESS) begin
                if (cur_pend) begin
                  ent_pend_clr = 1'b1;
                end else if (!cur_down) begin
                  ent_down_set   = 1'b1;
                  push           = 1'b1;
                  push_word.what = WHAT_PRESSED;
                end
              end else if (item_r.kind == KIND_RELEASE) begin
                if (cur_down) begin
                  ent_pend_set    = 1'b1;
                  mem_we          = 1'b1;
                  mem_wdata.rtime = item_r.event_time;
                end
              end else begin
                if (cur_down) begin
                  ent_pend_clr   = 1'b1;
                  push           = 1'b1;
                  push_word.what = WHAT_REPEATED;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_FINISH: begin
        finish_emit = held_v_r;
      end
    endcase
  end

  // Flag updates; a set wins over a clear of the same cycle.
  always_comb begin
    valid_nxt = valid_r;
    down_nxt  = down_r;
    pend_nxt  = pend_r;
    if (clear_all) begin
      valid_nxt = '0;
      down_nxt  = '0;
      pend_nxt  = '0;
    end else begin
      if (ent_valid_set) begin
        valid_nxt[ent_idx] = 1'b1;
      end
      if (ent_flags_clr || ent_down_clr) begin
        down_nxt[ent_idx] = 1'b0;
      end
      if (ent_flags_clr || ent_pend_clr) begin
        pend_nxt[ent_idx] = 1'b0;
      end
      if (ent_down_set) begin
        down_nxt[ent_idx] = 1'b1;
      end
      if (ent_pend_set) begin
        pend_nxt[ent_idx] = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_FLUSH;
      interval_r   <= '0;
      valid_r      <= '0;
      down_r       <= '0;
      pend_r       <= '0;
      issue_r      <= 1'b0;
      cnt_r        <= '0;
      p1_v_r       <= 1'b0;
      p2_v_r       <= 1'b0;
      held_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end

      // Sweep issue counter and pipeline valids.
      p1_v_r <= issue_r;
      p2_v_r <= p1_v_r;
      if (scan_start) begin
        mode_r  <= scan_mode;
        issue_r <= 1'b1;
        cnt_r   <= '0;
      end else if (issue_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end
      end

      valid_r <= valid_nxt;
      down_r  <= down_nxt;
      pend_r  <= pend_nxt;

      // A result waits in the held slot until the next one or the end of the item.
      out_strobe_r <= (push && held_v_r) || finish_emit;
      if (push) begin
        held_v_r <= 1'b1;
      end else if (finish_emit) begin
        held_v_r <= 1'b0;
      end
    end
  end

  // Item capture, sweep data path and result words.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    p1_idx_r <= cnt_r;

    // Deadline and match stage.
    p2_idx_r   <= p1_idx_r;
    p2_dl_r    <= dl_sat;
    p2_key_r   <= mem_rd_r.key;
    p2_dev_r   <= mem_rd_r.dev;
    p2_cand_r  <= valid_r[p1_idx_r] && pend_r[p1_idx_r];
    p2_match_r <= valid_r[p1_idx_r] && mem_rd_r.key == item_r.key_code &&
                  mem_rd_r.dev == item_r.device_id;
    p2_free_r  <= !valid_r[p1_idx_r];

    // Compare stage: strict less-than keeps ties in table order.
    if (scan_start) begin
      best_found_r  <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (p2_v_r) begin
      unique case (mode_r)
        MODE_FLUSH, MODE_QUERY: begin
          if (p2_cand_r && (mode_r == MODE_QUERY || p2_dl_r <= item_r.event_time) &&
              (!best_found_r || p2_dl_r < best_dl_r)) begin
            best_found_r <= 1'b1;
            best_idx_r   <= p2_idx_r;
            best_dl_r    <= p2_dl_r;
            best_key_r   <= p2_key_r;
            best_dev_r   <= p2_dev_r;
          end
        end
        MODE_FIND: begin
          if (p2_match_r) begin
            match_found_r <= 1'b1;
            match_idx_r   <= p2_idx_r;
          end
          if (p2_free_r && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= p2_idx_r;
          end
        end
        default: begin
        end
      endcase
    end

    if (push) begin
      held_r <= push_word;
      if (held_v_r) begin
        out_r <= {held_r.what, held_r.out_time, held_r.out_key_code,
                  held_r.out_device_id, 1'b0};
      end
    end else if (finish_emit) begin
      out_r <= {held_r.what, held_r.out_time, held_r.out_key_code,
                held_r.out_device_id, 1'b1};
    end
  end

  // Key table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[ent_idx] <= mem_wdata;
    end
    mem_rd_r <= mem_r[cnt_r];
  end

  // Results only come out of a running item.
  `KRD_ASSERT_NOW(a_strobe_from_item, clk, rst_n, out_strobe, $past(busy))
  // An accepted item always makes the block busy after it is taken.
  `KRD_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // Nothing follows the final word of an item.
  `KRD_ASSERT_NEXT(a_last_ends, clk, rst_n, out_strobe && out_data.last, !out_strobe)
  // The held slot is drained before the block goes idle.
  `KRD_ASSERT_NOW(a_idle_empty, clk, rst_n, state_r == ST_IDLE, !held_v_r)

endmodule

`default_nettype wire
